@@ rtl/core/raps_pkg.sv @@
// shared types and constants for the ring averaging particle step unit
`default_nettype none

package raps_pkg;

    localparam int POS_W = 32;
    localparam int CFG_W = 11;
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // stage controls from the sequencer to the move datapath
    typedef struct packed {
        logic load_pos;
        logic diff_en;
        logic mul_en;
        logic right;
    } move_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/ring_averaging_particle_step_unit.sv @@
// top level: sequencer, position memory and result register
`default_nettype none

// Keeps particle positions on a ring in one single-port memory with a
// registered read. Items are handled one at a time: a load writes as the
// word is taken, a no-op reads the particle, a restart reads particle 0 and
// then the particle, and a move reads the particle and its neighbour through
// the one memory port, then takes a difference stage, a multiply stage and a
// write-back. A word whose index is out of range skips its memory reads (a
// restart still reads particle 0). A finished result waits while the output
// register is still full. An item is taken while the previous result still
// waits at the output register. Positions must be loaded before they are read.
module ring_averaging_particle_step_unit
    import raps_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int FRACTION_BITS = 22,
    parameter int STEP_BITS     = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [CFG_W-1:0]                 cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [OP_W-1:0]                  s_opcode,
    input  wire logic [$clog2(MAX_PARTICLES)-1:0] s_particle_index,
    input  wire logic [POS_W-1:0]                 s_load_value,
    input  wire logic [STEP_BITS-1:0]             s_step_fraction,
    input  wire logic                             s_direction,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [POS_W-1:0]                      m_position_out,
    output logic signed [POS_W-1:0]               m_winding_count,
    output logic [POS_W-1:0]                      m_start_position
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int CLW   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFW   = (CNT_W + FRACTION_BITS > POS_W + 2) ?
                           CNT_W + FRACTION_BITS : POS_W + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RESTART = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_RD_NBR  = 3'd3;
    localparam logic [2:0] S_DIFF    = 3'd4;
    localparam logic [2:0] S_MUL     = 3'd5;
    localparam logic [2:0] S_WB      = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [STEP_BITS-1:0]   u_reg, u_next;
    logic                   dir_reg, dir_next;
    logic [POS_W-1:0]       res_pos_reg, res_pos_next;
    logic [POS_W-1:0]       turn_reg, turn_next;
    logic [POS_W-1:0]       start_reg, start_next;
    logic                   m_valid_reg, m_valid_next;
    logic [POS_W-1:0]       m_pos_reg, m_pos_next;
    logic [POS_W-1:0]       m_turn_reg, m_turn_next;
    logic [POS_W-1:0]       m_start_reg, m_start_next;

    logic [CLW-1:0]         count_w;
    logic [CNT_W-1:0]       n_eff;
    logic [CFW-1:0]         circ_wide;
    logic [POS_W:0]         circ;
    logic                   in_valid_idx;
    logic                   idx_ok_reg, idx_ok_next;
    logic [IDX_W-1:0]       nbr_idx;
    logic                   accept;
    logic                   out_load;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_addr;
    logic [POS_W-1:0]       ram_wdata;
    logic [POS_W-1:0]       ram_rdata;

    move_ctrl_t             alu_ctrl;
    logic [POS_W-1:0]       alu_pos;
    logic                   alu_wrapped;

    // effective count and circumference, saturated at 2^32
    always_comb begin
        count_w = CLW'(count_reg);
        if (count_w < CLW'(2)) begin
            n_eff = CNT_W'(2);
        end else if (count_w > CLW'(MAX_PARTICLES)) begin
            n_eff = CNT_W'(MAX_PARTICLES);
        end else begin
            n_eff = count_w[CNT_W-1:0];
        end
        circ_wide = CFW'(n_eff) << FRACTION_BITS;
        if (circ_wide > (CFW'(1) << POS_W)) begin
            circ = {1'b1, {POS_W{1'b0}}};
        end else begin
            circ = circ_wide[POS_W:0];
        end
    end

    assign in_valid_idx = CNT_W'(s_particle_index) < n_eff;
    assign s_ready      = (state_reg == S_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_load     = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        if (dir_reg) begin
            nbr_idx = (CNT_W'(idx_reg) + CNT_W'(1) == n_eff) ? '0 : idx_reg + IDX_W'(1);
        end else begin
            nbr_idx = (idx_reg == '0) ? IDX_W'(n_eff - CNT_W'(1)) : idx_reg - IDX_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = cfg_wr_en ? cfg_wr_data : count_reg;
        idx_next     = idx_reg;
        u_next       = u_reg;
        dir_next     = dir_reg;
        idx_ok_next  = idx_ok_reg;
        res_pos_next = res_pos_reg;
        turn_next    = turn_reg;
        start_next   = start_reg;
        ram_we       = 1'b0;
        ram_addr     = idx_reg;
        ram_wdata    = alu_pos;
        alu_ctrl     = '{load_pos: 1'b0, diff_en: 1'b0, mul_en: 1'b0, right: dir_reg};

        case (state_reg)
            S_IDLE: begin
                ram_addr = s_particle_index;
                if (accept) begin
                    idx_next    = s_particle_index;
                    u_next      = s_step_fraction;
                    dir_next    = s_direction;
                    idx_ok_next = in_valid_idx;
                    case (s_opcode)
                        OP_LOAD: begin
                            ram_we       = in_valid_idx;
                            ram_wdata    = s_load_value;
                            res_pos_next = in_valid_idx ? s_load_value : '0;
                            state_next   = S_DONE;
                        end
                        OP_MOVE: begin
                            res_pos_next = '0;
                            state_next   = in_valid_idx ? S_RD_NBR : S_DONE;
                        end
                        OP_RESTART: begin
                            ram_addr   = '0;
                            state_next = S_RESTART;
                        end
                        default: begin
                            res_pos_next = '0;
                            state_next   = in_valid_idx ? S_READ : S_DONE;
                        end
                    endcase
                end
            end
            S_RESTART: begin
                // memory now holds particle 0 on its read port
                start_next   = ram_rdata;
                turn_next    = '0;
                res_pos_next = '0;
                state_next   = idx_ok_reg ? S_READ : S_DONE;
            end
            S_READ: begin
                res_pos_next = ram_rdata;
                state_next   = S_DONE;
            end
            S_RD_NBR: begin
                alu_ctrl.load_pos = 1'b1;
                ram_addr          = nbr_idx;
                state_next        = S_DIFF;
            end
            S_DIFF: begin
                alu_ctrl.diff_en = 1'b1;
                state_next       = S_MUL;
            end
            S_MUL: begin
                alu_ctrl.mul_en = 1'b1;
                state_next      = S_WB;
            end
            S_WB: begin
                ram_we       = 1'b1;
                res_pos_next = alu_pos;
                if (alu_wrapped && idx_reg == '0) begin
                    turn_next = dir_reg ? turn_reg + POS_W'(1) : turn_reg - POS_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        m_turn_next  = m_turn_reg;
        m_start_next = m_start_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_pos_next   = res_pos_reg;
            m_turn_next  = turn_reg;
            m_start_next = start_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CFG_W'(1024);
            turn_reg    <= '0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            turn_reg    <= turn_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        u_reg       <= u_next;
        dir_reg     <= dir_next;
        idx_ok_reg  <= idx_ok_next;
        res_pos_reg <= res_pos_next;
        m_pos_reg   <= m_pos_next;
        m_turn_reg  <= m_turn_next;
        m_start_reg <= m_start_next;
    end

    raps_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_PARTICLES)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    raps_move_alu #(
        .STEP_BITS (STEP_BITS)
    ) u_move_alu (
        .aclk          (aclk),
        .ctrl          (alu_ctrl),
        .rdata         (ram_rdata),
        .circ          (circ),
        .step_fraction (u_reg),
        .new_pos       (alu_pos),
        .wrapped       (alu_wrapped)
    );

    assign m_valid          = m_valid_reg;
    assign m_position_out   = m_pos_reg;
    assign m_winding_count  = $signed(m_turn_reg);
    assign m_start_position = m_start_reg;

    // memory is written only as a word is taken or at move write-back
    a_ram_write_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_IDLE && accept) || state_reg == S_WB)
        else $error("position memory written outside a load or write-back");

    // winding count moves only at restart or write-back
    a_turn_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_WB && state_reg != S_RESTART) |=> $stable(turn_reg))
        else $error("winding count changed outside restart or write-back");

    // a finished result waits while the output register is still full
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> state_reg == S_DONE)
        else $error("result left while output register was full");

    // a move always runs its stages in order
    a_move_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD_NBR |=> state_reg == S_DIFF ##1 state_reg == S_MUL
                                  ##1 state_reg == S_WB)
        else $error("move stages out of order");

endmodule

`default_nettype wire

@@ rtl/core/raps_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module raps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/raps_move_alu.sv @@
// move datapath: ring distance, scaled step, wrap and saturation
`default_nettype none

module raps_move_alu
    import raps_pkg::*;
#(
    parameter int STEP_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire move_ctrl_t           ctrl,
    input  wire logic [POS_W-1:0]     rdata,
    input  wire logic [POS_W:0]       circ,
    input  wire logic [STEP_BITS-1:0] step_fraction,
    output logic      [POS_W-1:0]     new_pos,
    output logic                      wrapped
);

    localparam int DW = POS_W + 2;
    localparam int MW = POS_W + 1;
    localparam int NW = POS_W + 3;

    logic [POS_W-1:0]        pos_reg;
    logic [MW-1:0]           mag_reg;
    logic                    neg_reg;
    logic [MW+STEP_BITS-1:0] prod_reg;
    logic                    prod_neg_reg;

    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d_abs;
    logic        [MW-1:0] delta;
    logic signed [NW-1:0] np0;
    logic signed [NW-1:0] np1;
    logic signed [NW-1:0] c_n;
    logic signed [NW-1:0] pos_max;

    always_comb begin
        d0 = $signed({2'b00, rdata}) - $signed({2'b00, pos_reg});
        d1 = d0;
        if (ctrl.right && d0 < 0) begin
            d1 = d0 + $signed({1'b0, circ});
        end else if (!ctrl.right && d0 > 0) begin
            d1 = d0 - $signed({1'b0, circ});
        end
        d_abs = d1[DW-1] ? -d1 : d1;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_pos) begin
            pos_reg <= rdata;
        end
        if (ctrl.diff_en) begin
            mag_reg <= d_abs[MW-1:0];
            neg_reg <= d1[DW-1];
        end
        if (ctrl.mul_en) begin
            prod_reg     <= (MW+STEP_BITS)'(mag_reg) * (MW+STEP_BITS)'(step_fraction);
            prod_neg_reg <= neg_reg;
        end
    end

    // truncating shift of the product toward zero on the magnitude
    assign delta   = prod_reg[STEP_BITS +: MW];
    assign c_n     = $signed({2'b00, circ});
    assign pos_max = $signed({3'b000, {POS_W{1'b1}}});

    always_comb begin
        np0 = prod_neg_reg ? $signed({3'b000, pos_reg}) - $signed({2'b00, delta})
                           : $signed({3'b000, pos_reg}) + $signed({2'b00, delta});
        np1     = np0;
        wrapped = 1'b0;
        if (ctrl.right) begin
            if (np0 > c_n) begin
                np1     = np0 - c_n;
                wrapped = 1'b1;
            end
        end else begin
            if (np0 < 0) begin
                np1     = np0 + c_n;
                wrapped = 1'b1;
            end
        end
        if (np1 < 0) begin
            new_pos = '0;
        end else if (np1 > pos_max) begin
            new_pos = {POS_W{1'b1}};
        end else begin
            new_pos = np1[POS_W-1:0];
        end
    end

endmodule

`default_nettype wire
